// ===== rtl/jrss_pkg.sv =====
// shared types and constants for the job ratio stable sorter
// command and status structs between controller and datapath, state encoding
// no dependencies
package jrss_pkg;

   localparam int MAX_JOBS_DEF = 64;
   localparam int DUR_W        = 16;
   localparam int FINE_W       = 16;
   localparam int NUM_W        = 7;
   localparam int PROD_W       = DUR_W + FINE_W;
   localparam int ENTRY_W      = NUM_W + FINE_W + DUR_W;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_SCAN_RD,
      ST_SCAN_MUL,
      ST_SCAN_CMP,
      ST_SHIFT_CHK,
      ST_SHIFT_WR,
      ST_DRAIN_RD,
      ST_DRAIN_LOAD,
      ST_DRAIN_OUT
   } state_type;

   typedef struct packed {
      logic latch_job;
      logic mark_drop;
      logic clear_set;
      logic idx_zero;
      logic idx_inc;
      logic idx_dec;
      logic idx_from_count;
      logic pos_from_idx;
      logic rd_en;
      logic rd_prev;
      logic mul_en;
      logic wr_shift;
      logic wr_insert;
      logic out_load;
   } cmd_type;

   typedef struct packed {
      logic full;
      logic idx_at_count;
      logic idx_at_pos;
      logic idx_at_tail;
      logic ranks_ahead;
      logic last_job;
   } status_type;

endpackage

// ===== rtl/jrss_ram.sv =====
// generic simple dual-port ram, one write and one registered read port
// no dependencies
module jrss_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== rtl/jrss_datapath.sv =====
// datapath: job ram holding the sorted chain, index and count registers,
// ratio cross-multiplier and output registers; uses jrss_pkg and jrss_ram
module jrss_datapath #(
   parameter int MAX_JOBS = jrss_pkg::MAX_JOBS_DEF
) (
   input  logic                         clock,
   input  logic                         reset,
   input  jrss_pkg::cmd_type            cmd,
   output jrss_pkg::status_type         status,
   input  logic [jrss_pkg::DUR_W-1:0]   req_duration,
   input  logic [jrss_pkg::FINE_W-1:0]  req_fine,
   input  logic                         req_last_job,
   output logic [jrss_pkg::NUM_W-1:0]   rsp_job_number,
   output logic                         rsp_last_out,
   output logic                         rsp_overflowed
);
   import jrss_pkg::*;

   localparam int AW = $clog2(MAX_JOBS);
   localparam int CW = $clog2(MAX_JOBS + 1);

   logic [DUR_W-1:0]   new_dur_ff;
   logic [FINE_W-1:0]  new_fine_ff;
   logic               last_ff;
   logic [CW-1:0]      idx_ff, idx_in;
   logic [CW-1:0]      pos_ff;
   logic [CW-1:0]      count_ff, count_in;
   logic               dropped_ff, dropped_in;
   logic [PROD_W-1:0]  prod_new_ff;
   logic [PROD_W-1:0]  prod_old_ff;
   logic [NUM_W-1:0]   out_num_ff;
   logic               out_last_ff;
   logic               out_ovf_ff;

   logic [ENTRY_W-1:0] rd_data;
   logic [ENTRY_W-1:0] wr_data;
   logic [AW-1:0]      rd_addr;
   logic [AW-1:0]      wr_addr;
   logic [CW-1:0]      idx_prev;
   logic [DUR_W-1:0]   old_dur;
   logic [FINE_W-1:0]  old_fine;
   logic [NUM_W-1:0]   old_num;

   assign old_dur  = rd_data[DUR_W-1:0];
   assign old_fine = rd_data[DUR_W +: FINE_W];
   assign old_num  = rd_data[DUR_W+FINE_W +: NUM_W];

   assign idx_prev = idx_ff - CW'(1);
   assign rd_addr  = cmd.rd_prev ? idx_prev[AW-1:0] : idx_ff[AW-1:0];
   assign wr_addr  = idx_ff[AW-1:0];
   // shifting moves the read entry up one place, insertion writes the new job
   assign wr_data  = cmd.wr_insert
                   ? {NUM_W'(count_ff) + NUM_W'(1), new_fine_ff, new_dur_ff}
                   : rd_data;

   jrss_ram #(
      .WIDTH (ENTRY_W),
      .DEPTH (MAX_JOBS)
   ) u_job_ram (
      .clock   (clock),
      .wr_en   (cmd.wr_shift | cmd.wr_insert),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (cmd.rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   always_comb begin
      idx_in = idx_ff;
      if (cmd.idx_zero) begin
         idx_in = '0;
      end else if (cmd.idx_inc) begin
         idx_in = idx_ff + CW'(1);
      end else if (cmd.idx_dec) begin
         idx_in = idx_prev;
      end else if (cmd.idx_from_count) begin
         idx_in = count_ff;
      end
   end

   always_comb begin
      count_in   = count_ff;
      dropped_in = dropped_ff;
      if (cmd.clear_set) begin
         count_in   = '0;
         dropped_in = 1'b0;
      end else begin
         if (cmd.wr_insert) begin
            count_in = count_ff + CW'(1);
         end
         if (cmd.mark_drop) begin
            dropped_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff     <= '0;
         count_ff   <= '0;
         dropped_ff <= 1'b0;
      end else begin
         idx_ff     <= idx_in;
         count_ff   <= count_in;
         dropped_ff <= dropped_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.latch_job) begin
         new_dur_ff  <= req_duration;
         new_fine_ff <= req_fine;
         last_ff     <= req_last_job;
      end
      if (cmd.pos_from_idx) begin
         pos_ff <= idx_ff;
      end
      if (cmd.mul_en) begin
         prod_new_ff <= PROD_W'(new_fine_ff) * PROD_W'(old_dur);
         prod_old_ff <= PROD_W'(old_fine) * PROD_W'(new_dur_ff);
      end
      if (cmd.out_load) begin
         out_num_ff  <= old_num;
         out_last_ff <= (idx_ff + CW'(1)) == count_ff;
         out_ovf_ff  <= dropped_ff;
      end
   end

   assign status.full         = count_ff == CW'(MAX_JOBS);
   assign status.idx_at_count = idx_ff == count_ff;
   assign status.idx_at_pos   = idx_ff == pos_ff;
   assign status.idx_at_tail  = (idx_ff + CW'(1)) == count_ff;
   assign status.ranks_ahead  = prod_new_ff > prod_old_ff;
   assign status.last_job     = last_ff;

   assign rsp_job_number = out_num_ff;
   assign rsp_last_out   = out_last_ff;
   assign rsp_overflowed = out_ovf_ff;

endmodule

// ===== rtl/jrss_ctrl.sv =====
// controller: sequences scan, shift, insert and drain over the job ram
// uses jrss_pkg
module jrss_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   input  logic                 req_last_job,
   output logic                 req_stall,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   input  jrss_pkg::status_type status,
   output jrss_pkg::cmd_type    cmd
);
   import jrss_pkg::*;

   state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               if (!status.full) begin
                  state_in = ST_SCAN_RD;
               end else if (req_last_job) begin
                  state_in = ST_DRAIN_RD;
               end
            end
         end
         ST_SCAN_RD: begin
            state_in = status.idx_at_count ? ST_SHIFT_CHK : ST_SCAN_MUL;
         end
         ST_SCAN_MUL: begin
            state_in = ST_SCAN_CMP;
         end
         ST_SCAN_CMP: begin
            state_in = status.ranks_ahead ? ST_SHIFT_CHK : ST_SCAN_RD;
         end
         ST_SHIFT_CHK: begin
            if (!status.idx_at_pos) begin
               state_in = ST_SHIFT_WR;
            end else if (status.last_job) begin
               state_in = ST_DRAIN_RD;
            end else begin
               state_in = ST_IDLE;
            end
         end
         ST_SHIFT_WR: begin
            state_in = ST_SHIFT_CHK;
         end
         ST_DRAIN_RD: begin
            state_in = status.idx_at_count ? ST_IDLE : ST_DRAIN_LOAD;
         end
         ST_DRAIN_LOAD: begin
            state_in = ST_DRAIN_OUT;
         end
         ST_DRAIN_OUT: begin
            if (!rsp_stall) begin
               state_in = status.idx_at_tail ? ST_IDLE : ST_DRAIN_RD;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      cmd       = '0;
      req_stall = 1'b1;
      rsp_valid = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_stall = 1'b0;
            if (req_valid) begin
               cmd.latch_job = 1'b1;
               cmd.idx_zero  = 1'b1;
               cmd.mark_drop = status.full;
            end
         end
         ST_SCAN_RD: begin
            if (status.idx_at_count) begin
               // nothing outranked, job goes at the end of the chain
               cmd.pos_from_idx = 1'b1;
            end else begin
               cmd.rd_en = 1'b1;
            end
         end
         ST_SCAN_MUL: begin
            cmd.mul_en = 1'b1;
         end
         ST_SCAN_CMP: begin
            if (status.ranks_ahead) begin
               cmd.pos_from_idx   = 1'b1;
               cmd.idx_from_count = 1'b1;
            end else begin
               cmd.idx_inc = 1'b1;
            end
         end
         ST_SHIFT_CHK: begin
            if (!status.idx_at_pos) begin
               cmd.rd_en   = 1'b1;
               cmd.rd_prev = 1'b1;
            end else begin
               cmd.wr_insert = 1'b1;
               cmd.idx_zero  = status.last_job;
            end
         end
         ST_SHIFT_WR: begin
            cmd.wr_shift = 1'b1;
            cmd.idx_dec  = 1'b1;
         end
         ST_DRAIN_RD: begin
            if (status.idx_at_count) begin
               cmd.clear_set = 1'b1;
            end else begin
               cmd.rd_en = 1'b1;
            end
         end
         ST_DRAIN_LOAD: begin
            cmd.out_load = 1'b1;
         end
         ST_DRAIN_OUT: begin
            rsp_valid = 1'b1;
            if (!rsp_stall) begin
               if (status.idx_at_tail) begin
                  cmd.clear_set = 1'b1;
               end else begin
                  cmd.idx_inc = 1'b1;
               end
            end
         end
         default: begin
            cmd = '0;
         end
      endcase
   end

endmodule

// ===== rtl/job_ratio_stable_sorter.sv =====
// top level of the job ratio stable sorter
// joins jrss_ctrl and jrss_datapath; uses jrss_pkg
//
// Orders a set of jobs by descending fine/duration (Smith's rule), stable on
// equal ratios, with the ratio compare done exactly as fine_a*dur_b versus
// fine_b*dur_a. Jobs are numbered from 1 in arrival order and kept as a
// sorted chain in one job ram; the job carrying req_last_job triggers a burst
// of rsp transactions, one per held job, in chain order, with rsp_last_out on
// the final one. Jobs arriving while MAX_JOBS are held are dropped and every
// result of that set carries rsp_overflowed. One job is handled at a time:
// the scan reads, multiplies and compares one held entry at a time from the
// head of the chain until the new job ranks ahead or the end is met, and the
// shift then moves each later entry up one place through the single read
// port of the ram before the new job is written. The drain gives one result
// at a time and holds while rsp_stall is high. No clearing pass is needed
// after reset.
module job_ratio_stable_sorter #(
   parameter int MAX_JOBS = jrss_pkg::MAX_JOBS_DEF
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_stall,
   input  logic [jrss_pkg::DUR_W-1:0]   req_duration,
   input  logic [jrss_pkg::FINE_W-1:0]  req_fine,
   input  logic                         req_last_job,
   output logic                         rsp_valid,
   input  logic                         rsp_stall,
   output logic [jrss_pkg::NUM_W-1:0]   rsp_job_number,
   output logic                         rsp_last_out,
   output logic                         rsp_overflowed
);
   import jrss_pkg::*;

   cmd_type    cmd;
   status_type status;

   jrss_ctrl u_ctrl (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_last_job (req_last_job),
      .req_stall    (req_stall),
      .rsp_valid    (rsp_valid),
      .rsp_stall    (rsp_stall),
      .status       (status),
      .cmd          (cmd)
   );

   jrss_datapath #(
      .MAX_JOBS (MAX_JOBS)
   ) u_datapath (
      .clock          (clock),
      .reset          (reset),
      .cmd            (cmd),
      .status         (status),
      .req_duration   (req_duration),
      .req_fine       (req_fine),
      .req_last_job   (req_last_job),
      .rsp_job_number (rsp_job_number),
      .rsp_last_out   (rsp_last_out),
      .rsp_overflowed (rsp_overflowed)
   );

endmodule
